>>> sv/flood_packet_dedup_relay_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the flood packet relay.
// Each macro checks one implication on the rising edge of clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef FLOOD_PACKET_DEDUP_RELAY_ASSERT_SVH
`define FLOOD_PACKET_DEDUP_RELAY_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FPDR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FPDR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/fpdr_pkg.sv
// ----------------------------------------------------------------------------
// fpdr_pkg
// Shared constants and types of the flood packet relay and its seen cache.
// ----------------------------------------------------------------------------
package fpdr_pkg;

  localparam int CACHE_DEPTH = 16;
  localparam int IDX_W = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
  localparam int ADDR_W = 24;
  localparam int FID_W = 8;

  localparam logic [7:0]  FORMAT_TYPE    = 8'hff;
  localparam logic [15:0] FORMAT_COMPANY = 16'he002;
  localparam logic [47:0] TAG_MAGIC      = 48'h53484F455321;
  localparam logic [7:0]  KIND_FLOOD     = 8'h01;
  localparam logic [7:0]  BOTH_COLORS    = 8'd3;
  localparam logic [15:0] LIGHT_TIME_RST = 16'd300;

  typedef enum logic [2:0] {
    ST_BAD_CRC = 3'd0,
    ST_FOREIGN = 3'd1,
    ST_OTHER   = 3'd2,
    ST_OWN     = 3'd3,
    ST_SEEN    = 3'd4,
    ST_JOINED  = 3'd5,
    ST_FLAG    = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    MODE_RX          = 2'd0,
    MODE_FLOOD_START = 2'd1,
    MODE_TIMER       = 2'd2
  } mode_t;

  typedef enum logic [0:0] {
    REG_OWN_ADDRESS = 1'b0,
    REG_LIGHT_TIME  = 1'b1
  } reg_idx_t;

  // Input item payload, last declared field in the lowest bits.
  typedef struct packed {
    logic [6:0]  pad;
    logic [23:0] initiator;
    logic [15:0] delay_ms;
    logic [7:0]  flood_color;
    logic [7:0]  hops;
    logic [7:0]  flood_seq;
    logic [7:0]  packet_kind;
    logic [47:0] name_tag;
    logic [15:0] company_id;
    logic [7:0]  ad_type;
    logic        crc_ok;
  } in_t;

  // Result item payload, last declared field in the lowest bits.
  typedef struct packed {
    logic [15:0] led_wait_ms;
    logic [7:0]  led_color;
    logic [23:0] relay_initiator;
    logic [7:0]  relay_color;
    logic [7:0]  relay_hop;
    logic [7:0]  relay_seq;
  } out_t;

  localparam int IN_W  = $bits(in_t);
  localparam int OUT_W = $bits(out_t);

  // Search token that walks the row of cache cells.
  typedef struct packed {
    logic              valid;
    logic              known;
    logic              hit;
    logic [IDX_W-1:0]  hit_idx;
    logic [ADDR_W-1:0] who;
    logic [FID_W-1:0]  fid;
  } tok_t;

  // Write command broadcast to the cells.
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  idx;
    logic [ADDR_W-1:0] who;
    logic [FID_W-1:0]  fid;
  } wr_t;

endpackage

>>> sv/flood_packet_dedup_relay.sv
// ----------------------------------------------------------------------------
// flood_packet_dedup_relay
// Classifies radio events, drops repeated floods through a small seen cache
// and gives the relay and LED fields for floods this node joins.
// ----------------------------------------------------------------------------
// Flag events and rejected packets give their result in the cycle after
// acceptance and can be taken in every cycle while the output is not held.
// A flood that reaches the cache search walks the row of cells one cell per
// cycle, its result is then registered, and the next item can be taken as
// soon as that result is in the result register and the output is free. The
// result register lets a new item in while the previous result is being taken.
module flood_packet_dedup_relay import fpdr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  // crc_ok, ad_type, company_id, name_tag, packet_kind, flood_seq, hops,
  // flood_color, delay_ms, initiator, zero fill
  input  logic [IN_W-1:0]   s_tdata,
  // mode
  input  logic [1:0]        s_tuser,
  output logic              m_tvalid,
  input  logic              m_tready,
  // relay_seq, relay_hop, relay_color, relay_initiator, led_color,
  // led_wait_ms
  output logic [OUT_W-1:0]  m_tdata,
  // status
  output logic [2:0]        m_tuser,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [0:0]        cfg_index,
  input  logic [23:0]       cfg_data
);

  `include "flood_packet_dedup_relay_assert.svh"

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LOOK = 3'b010,
    S_HOLD = 3'b100
  } state_t;

  state_t state, state_next;

  in_t     item;
  logic    s_acc;
  logic    out_free;
  logic    need_lookup;
  status_t quick;
  tok_t    launch;
  tok_t    res;

  logic [23:0] own_address;
  logic [15:0] light_period;
  logic        in_flood;

  logic [7:0]  fid_q;
  logic [7:0]  hop_q;
  logic [7:0]  col_q;
  logic [15:0] dly_q;
  logic [23:0] who_q;
  logic        known_q;

  logic    fin;
  logic    fin_known;
  logic    fin_load;
  out_t    joined_data;
  out_t    m_data;
  status_t m_status;

  assign item      = in_t'(s_tdata);
  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (state == S_IDLE) && out_free;
  assign s_acc     = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign m_tdata   = m_data;
  assign m_tuser   = m_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address  <= '0;
      light_period <= LIGHT_TIME_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_OWN_ADDRESS: own_address <= cfg_data;
        REG_LIGHT_TIME:  light_period <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    need_lookup = 1'b0;
    quick = ST_FLAG;
    if (s_tuser != MODE_RX) begin
      quick = ST_FLAG;
    end else if (!item.crc_ok) begin
      quick = ST_BAD_CRC;
    end else if ((item.ad_type != FORMAT_TYPE) || (item.company_id != FORMAT_COMPANY) ||
                 (item.name_tag != TAG_MAGIC)) begin
      quick = ST_FOREIGN;
    end else if (item.packet_kind != KIND_FLOOD) begin
      quick = ST_OTHER;
    end else if (item.initiator == own_address) begin
      quick = ST_OWN;
    end else begin
      need_lookup = 1'b1;
    end
  end

  always_comb begin
    launch = '0;
    launch.valid = s_acc && need_lookup;
    launch.who = item.initiator;
    launch.fid = item.flood_seq;
  end

  fpdr_cache u_cache (
    .clk    (clk),
    .rst    (rst),
    .launch (launch),
    .res    (res)
  );

  assign fin       = ((state == S_LOOK) && res.valid) || (state == S_HOLD);
  assign fin_known = (state == S_LOOK) ? res.known : known_q;
  assign fin_load  = fin && out_free;

  always_comb begin
    joined_data.relay_seq       = fid_q;
    joined_data.relay_hop       = hop_q + 8'd1;
    joined_data.relay_color     = col_q;
    joined_data.relay_initiator = who_q;
    joined_data.led_color       = in_flood ? BOTH_COLORS : col_q;
    joined_data.led_wait_ms     = (light_period > dly_q) ? (light_period - dly_q) : 16'd0;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_acc && need_lookup) begin
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        if (res.valid) begin
          state_next = fin_load ? S_IDLE : S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      in_flood <= 1'b0;
    end else begin
      state <= state_next;
      if ((s_acc && !need_lookup) || fin_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (s_acc && (s_tuser == MODE_FLOOD_START)) begin
        in_flood <= 1'b1;
      end else if (s_acc && (s_tuser == MODE_TIMER)) begin
        in_flood <= 1'b0;
      end else if (fin_load && !fin_known) begin
        in_flood <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      fid_q <= item.flood_seq;
      hop_q <= item.hops;
      col_q <= item.flood_color;
      dly_q <= item.delay_ms;
      who_q <= item.initiator;
    end
    if ((state == S_LOOK) && res.valid) begin
      known_q <= res.known;
    end
    if (s_acc && !need_lookup) begin
      m_status <= quick;
      m_data   <= '0;
    end else if (fin_load) begin
      m_status <= fin_known ? ST_SEEN : ST_JOINED;
      m_data   <= fin_known ? '0 : joined_data;
    end
  end

  `FPDR_ASSERT_SAME(a_res_in_look, res.valid, state == S_LOOK,
    "cache result outside a search")
  `FPDR_ASSERT_NEXT(a_lookup_starts, s_acc && need_lookup, state == S_LOOK,
    "accepted flood did not start a search")
  `FPDR_ASSERT_SAME(a_joined_sets_flag, m_tvalid && (m_tuser == ST_JOINED), in_flood,
    "joined result without the in-flood flag")
  `FPDR_ASSERT_SAME(a_zero_unless_joined, m_tvalid && (m_tuser != ST_JOINED), m_tdata == '0,
    "nonzero relay fields on a result that is not joined")
  `FPDR_ASSERT_SAME(a_hold_has_output, state == S_HOLD, m_tvalid,
    "waiting for the output with an empty output register")

endmodule

>>> sv/fpdr_cell.sv
// ----------------------------------------------------------------------------
// fpdr_cell
// One cache entry. Matches the passing token against its pair and registers the
// token for the next cell.
// ----------------------------------------------------------------------------
module fpdr_cell import fpdr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] pos,
  input  tok_t             tok_in,
  input  wr_t              wr,
  output tok_t             tok_out
);

  logic [ADDR_W-1:0] ini;
  logic [FID_W-1:0]  fid;
  logic              ini_eq;
  tok_t              tok_next;

  assign ini_eq = (ini == tok_in.who);

  always_comb begin
    tok_next = tok_in;
    tok_next.known = tok_in.known || (ini_eq && (fid == tok_in.fid));
    if (!tok_in.hit && ini_eq) begin
      tok_next.hit = 1'b1;
      tok_next.hit_idx = pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ini <= '0;
      fid <= '0;
    end else if (wr.en && (wr.idx == pos)) begin
      ini <= wr.who;
      fid <= wr.fid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

>>> sv/fpdr_cache.sv
// ----------------------------------------------------------------------------
// fpdr_cache
// Row of cache cells with the ring head. A finished search that found no
// matching pair stores it, in the initiator's entry or at the ring head.
// ----------------------------------------------------------------------------
module fpdr_cache import fpdr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  tok_t launch,
  output tok_t res
);

  tok_t             chain [CACHE_DEPTH];
  wr_t              wr;
  logic [IDX_W-1:0] head;

  for (genvar k = 0; k < CACHE_DEPTH; k++) begin : g_cell
    fpdr_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .pos     (IDX_W'(k)),
      .tok_in  ((k == 0) ? launch : chain[(k == 0) ? 0 : k - 1]),
      .wr      (wr),
      .tok_out (chain[k])
    );
  end

  assign res = chain[CACHE_DEPTH-1];

  always_comb begin
    wr.en  = res.valid && !res.known;
    wr.idx = res.hit ? res.hit_idx : head;
    wr.who = res.who;
    wr.fid = res.fid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
    end else if (wr.en && !res.hit) begin
      if (head == IDX_W'(CACHE_DEPTH - 1)) begin
        head <= '0;
      end else begin
        head <= head + 1'b1;
      end
    end
  end

endmodule
